[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
// Every check is sampled on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define TACU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a sampled edge.
`define TACU_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[rtl/tacu_pkg.sv]
package tacu_pkg;

	localparam int DIV_WIDTH = 32;
	localparam int SEND_BUFFER_BYTES_DEF = 65536;

	localparam logic [1:0] OP_SEG_ARRIVED = 2'd0;
	localparam logic [1:0] OP_DATA_QUEUED = 2'd1;
	localparam logic [1:0] OP_SEG_SENT    = 2'd2;

	localparam logic [1:0] RTO_NONE   = 2'd0;
	localparam logic [1:0] RTO_CANCEL = 2'd1;
	localparam logic [1:0] RTO_REARM  = 2'd2;

	localparam logic [1:0] CFG_MSS      = 2'd0;
	localparam logic [1:0] CFG_SSTHRESH = 2'd1;
	localparam logic [1:0] CFG_SNDBUF   = 2'd2;

	localparam logic [15:0] MSS_RESET      = 16'd536;
	localparam logic [31:0] SSTHRESH_RESET = 32'd65535;
	localparam logic [16:0] SNDBUF_RESET   = 17'd65536;
	localparam logic [31:0] CWND_RESET     = 32'd536;

	typedef struct packed {
		logic [1:0]  op;
		logic        established;
		logic        ack_flag;
		logic [31:0] ack_number;
		logic [15:0] window_size;
		logic [15:0] segment_data_len;
		logic [16:0] byte_count;
		logic        start_rtt;
	} in_word_t;

	typedef struct packed {
		logic [31:0] unacked_seq;
		logic [31:0] congestion_window;
		logic [15:0] buffer_start;
		logic [16:0] buffer_len;
		logic [16:0] bytes_freed;
		logic [7:0]  dup_ack_count;
		logic        rtt_done;
		logic [1:0]  rto_action;
	} out_word_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[rtl/tacu_div.sv]
module tacu_div #(
	parameter int WIDTH = tacu_pkg::DIV_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WIDTH-1:0]     dividend,
	input  logic [WIDTH-1:0]     divisor,
	output tacu_pkg::div_status_t status,
	output logic [WIDTH-1:0]     quotient,
	output logic [WIDTH-1:0]     remainder
);

	localparam int CW = $clog2(WIDTH) + 1;

	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;

	logic [WIDTH:0]   shifted;
	logic             ge;
	logic [WIDTH:0]   sub;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		shifted = {rem_q, quo_q[WIDTH-1]};
		ge      = shifted >= {1'b0, dvs_q};
		sub     = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= !start && cnt_q == CW'(1);
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				dvs_q <= divisor;
				cnt_q <= CW'(WIDTH);
			end else if (cnt_q != '0) begin
				quo_q <= {quo_q[WIDTH-2:0], ge};
				rem_q <= ge ? sub[WIDTH-1:0] : shifted[WIDTH-1:0];
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign status.busy = cnt_q != '0;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q;

endmodule

[rtl/tcp_ack_congestion_update_top.sv]
// Send-side acknowledgement and congestion window update for one TCP connection.
// Input channel (in_valid, in_ready, in_data) takes one event word: an arriving
// segment, bytes queued into the send buffer, or a segment sent. Every event
// gives exactly one result word on the output channel (out_valid, out_ready,
// out_data) holding the connection state after the event.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and writes MSS, slow start threshold and send buffer size.
// The block handles one event at a time and drops in_ready while it works.
// Most events pass through S_EXEC and S_FIN to the output register, and in_ready
// rises again as the result is written. A new acknowledgement adds S_GROW and
// S_ADD in slow start, and S_MUL and S_DIV as well in congestion avoidance,
// where one 32-bit serial divider forms MSS*MSS/cwnd one quotient bit per cycle.
// When the buffer start wraps, the same divider first forms the modulo in S_MOD.
// Reset returns all connection state and registers to their initial values.
// A finished result waits in the output register while the receiver stalls;
// one more event may be accepted meanwhile and waits for that register.
module tcp_ack_congestion_update_top #(
	parameter int SEND_BUFFER_BYTES = tacu_pkg::SEND_BUFFER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tacu_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tacu_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	`include "assert_macros.svh"

	localparam logic [16:0] BUF_BYTES = 17'(SEND_BUFFER_BYTES);
	localparam int DW = tacu_pkg::DIV_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_MOD, S_GROW, S_MUL, S_DIV, S_ADD, S_FIN
	} state_t;

	state_t state_q;

	logic [15:0] mss_q;
	logic [31:0] ssthresh_q;
	logic [16:0] sndbuf_q;

	tacu_pkg::in_word_t  in_q;
	tacu_pkg::out_word_t out_q;
	logic                out_valid_q;

	logic [31:0] una_q;
	logic [31:0] next_q;
	logic [15:0] head_q;
	logic [16:0] count_q;
	logic [31:0] cwnd_q;
	logic [7:0]  dup_q;
	logic [15:0] peer_win_q;
	logic        rtt_pend_q;
	logic [31:0] rtt_target_q;
	logic [16:0] freed_q;
	logic        rdone_q;
	logic [1:0]  rto_q;
	logic [31:0] prod_q;
	logic [31:0] adj_q;

	logic [16:0] eff_size;
	logic [31:0] ack_diff;
	logic [31:0] rtt_diff;
	logic        is_ack;
	logic        ack_ok;
	logic        new_ack;
	logic [16:0] freed;
	logic [16:0] head_sum;
	logic        wrap;
	logic [17:0] queue_sum;
	logic [31:0] next_sum;
	logic [31:0] adj_fix;
	logic [32:0] cw_sum;
	logic        div_start;
	logic [DW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;
	tacu_pkg::div_status_t div_stat;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] div_rem;
	logic        out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		eff_size  = (sndbuf_q == '0 || sndbuf_q > BUF_BYTES) ? BUF_BYTES : sndbuf_q;
		ack_diff  = in_q.ack_number - una_q;
		rtt_diff  = in_q.ack_number - rtt_target_q;
		is_ack    = in_q.op == tacu_pkg::OP_SEG_ARRIVED && in_q.established && in_q.ack_flag;
		ack_ok    = is_ack && !ack_diff[31];
		new_ack   = ack_ok && ack_diff != '0;
		freed     = (ack_diff < {15'd0, count_q}) ? ack_diff[16:0] : count_q;
		head_sum  = {1'b0, head_q} + freed;
		wrap      = head_sum >= eff_size;
		queue_sum = {1'b0, count_q} + {1'b0, in_q.byte_count};
		next_sum  = next_q + {15'd0, in_q.byte_count};
		adj_fix   = (adj_q == '0) ? 32'd1 : adj_q;
		cw_sum    = {1'b0, cwnd_q} + {1'b0, adj_fix};
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = prod_q;
		div_divisor  = cwnd_q;
		if (state_q == S_EXEC) begin
			div_start    = new_ack && wrap;
			div_dividend = {15'd0, head_sum};
			div_divisor  = {15'd0, eff_size};
		end else if (state_q == S_MUL) begin
			div_start = cwnd_q != '0;
		end
	end

	tacu_div #(
		.WIDTH(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.status   (div_stat),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q      <= tacu_pkg::MSS_RESET;
			ssthresh_q <= tacu_pkg::SSTHRESH_RESET;
			sndbuf_q   <= tacu_pkg::SNDBUF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tacu_pkg::CFG_MSS:      mss_q      <= cfg_data[15:0];
				tacu_pkg::CFG_SSTHRESH: ssthresh_q <= cfg_data;
				tacu_pkg::CFG_SNDBUF:   sndbuf_q   <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			una_q        <= '0;
			next_q       <= '0;
			head_q       <= '0;
			count_q      <= '0;
			cwnd_q       <= tacu_pkg::CWND_RESET;
			dup_q        <= '0;
			peer_win_q   <= '0;
			rtt_pend_q   <= 1'b0;
			rtt_target_q <= '0;
			freed_q      <= '0;
			rdone_q      <= 1'b0;
			rto_q        <= tacu_pkg::RTO_NONE;
			prod_q       <= '0;
			adj_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					freed_q <= new_ack ? freed : '0;
					rdone_q <= ack_ok && rtt_pend_q && !rtt_diff[31];
					if (!new_ack) begin
						rto_q <= tacu_pkg::RTO_NONE;
					end else if (in_q.ack_number != next_q) begin
						rto_q <= tacu_pkg::RTO_REARM;
					end else begin
						rto_q <= tacu_pkg::RTO_CANCEL;
					end
					if (!new_ack) begin
						state_q <= S_FIN;
					end else if (wrap) begin
						state_q <= S_MOD;
					end else begin
						state_q <= S_GROW;
					end
					case (in_q.op)
						tacu_pkg::OP_SEG_ARRIVED: begin
							if (ack_ok) begin
								peer_win_q <= in_q.window_size;
								if (rtt_pend_q && !rtt_diff[31]) begin
									rtt_pend_q <= 1'b0;
								end
								if (ack_diff == '0) begin
									if (in_q.segment_data_len == '0
										&& in_q.window_size == peer_win_q
										&& dup_q != 8'hFF) begin
										dup_q <= dup_q + 8'd1;
									end
								end else begin
									count_q <= count_q - freed;
									una_q   <= in_q.ack_number;
									dup_q   <= '0;
									if (!wrap) begin
										head_q <= head_sum[15:0];
									end
								end
							end
						end
						tacu_pkg::OP_DATA_QUEUED: begin
							count_q <= (queue_sum > {1'b0, eff_size}) ?
								eff_size : queue_sum[16:0];
						end
						tacu_pkg::OP_SEG_SENT: begin
							next_q <= next_sum;
							if (in_q.start_rtt && !rtt_pend_q) begin
								rtt_pend_q   <= 1'b1;
								rtt_target_q <= next_sum;
							end
						end
						default: begin
						end
					endcase
				end
				S_MOD: begin
					if (div_stat.done) begin
						head_q  <= div_rem[15:0];
						state_q <= S_GROW;
					end
				end
				S_GROW: begin
					prod_q <= {16'd0, mss_q} * {16'd0, mss_q};
					if (cwnd_q < ssthresh_q) begin
						adj_q   <= {16'd0, mss_q};
						state_q <= S_ADD;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (cwnd_q == '0) begin
						adj_q   <= prod_q;
						state_q <= S_ADD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						adj_q   <= div_quo;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					cwnd_q  <= cw_sum[32] ? 32'hFFFF_FFFF : cw_sum[31:0];
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q             <= 1'b1;
						out_q.unacked_seq       <= una_q;
						out_q.congestion_window <= cwnd_q;
						out_q.buffer_start      <= head_q;
						out_q.buffer_len        <= count_q;
						out_q.bytes_freed       <= freed_q;
						out_q.dup_ack_count     <= dup_q;
						out_q.rtt_done          <= rdone_q;
						out_q.rto_action        <= rto_q;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TACU_ASSERT(a_cwnd_grows, cwnd_q >= $past(cwnd_q), "congestion window decreased")
	`TACU_ASSERT(a_div_done_owned, div_stat.done |-> (state_q == S_MOD || state_q == S_DIV), "divider finished outside a divide state")
	`TACU_NEVER(a_ready_while_div, in_ready && div_stat.busy, "ready while the divider is busy")
	`TACU_NEVER(a_rtt_done_pending, state_q == S_FIN && rdone_q && rtt_pend_q, "round trip done but still pending")

endmodule

[bench/tb_tcp_ack_congestion_update_top.sv]
module tb_tcp_ack_congestion_update_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tacu_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int RING_BYTES = SEND_BUFFER_BYTES_DEF;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 140;
	localparam int DUP_RUN = 270;
	localparam int N_DIRECTED = 19;

	typedef struct packed {
		in_word_t  w;
		logic      typed;
		out_word_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_word_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// Connection state and registers as the block should hold them.
	logic [15:0] reg_mss;
	logic [31:0] reg_ssthresh;
	logic [16:0] reg_sndbuf;
	logic [31:0] snd_una;
	logic [31:0] snd_nxt;
	logic [15:0] ring_head;
	logic [16:0] ring_count;
	logic [31:0] cwnd;
	logic [7:0]  dup_run;
	logic [15:0] peer_win;
	logic        rtt_armed;
	logic [31:0] rtt_mark;

	out_word_t pending_states [$];
	int        n_errors;
	int        n_words;
	int        n_new_acks;
	int        n_avoid;
	int        n_wraps;
	int        n_rtt_done;
	int        n_rearms;
	int        peak_dups;
	int        burst_left;
	int        quiet;
	bit        hold_req;

	tcp_ack_congestion_update_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic in_word_t event_word(logic [1:0] op, logic est, logic ackf,
			logic [31:0] ackn, logic [15:0] win, logic [15:0] dlen, logic [16:0] cnt,
			logic srtt);
		in_word_t w;
		w.op = op;
		w.established = est;
		w.ack_flag = ackf;
		w.ack_number = ackn;
		w.window_size = win;
		w.segment_data_len = dlen;
		w.byte_count = cnt;
		w.start_rtt = srtt;
		return w;
	endfunction

	function automatic out_word_t state_word(logic [31:0] una, logic [31:0] cw,
			logic [15:0] start, logic [16:0] len, logic [16:0] freed, logic [7:0] dups,
			logic rdone, logic [1:0] rto);
		out_word_t r;
		r.unacked_seq = una;
		r.congestion_window = cw;
		r.buffer_start = start;
		r.buffer_len = len;
		r.bytes_freed = freed;
		r.dup_ack_count = dups;
		r.rtt_done = rdone;
		r.rto_action = rto;
		return r;
	endfunction

	// Applies one event word to the connection state and returns the state word it yields.
	function automatic out_word_t ack_update(in_word_t w);
		logic [31:0] adv;
		logic [31:0] rtt_gap;
		logic [31:0] ring_size;
		logic [31:0] fill;
		logic [63:0] mss2;
		logic [63:0] inc;
		logic [63:0] total;
		logic [16:0] freed;
		logic        rdone;
		logic [1:0]  rto;
		freed = '0;
		rdone = 1'b0;
		rto = RTO_NONE;
		ring_size = (reg_sndbuf == 0 || 32'(reg_sndbuf) > RING_BYTES) ? RING_BYTES
			: 32'(reg_sndbuf);
		case (w.op)
			OP_SEG_ARRIVED: begin
				adv = w.ack_number - snd_una;
				if (w.established && w.ack_flag && !adv[31]) begin
					if (adv == 0) begin
						if (w.segment_data_len == 0 && w.window_size == peer_win
								&& dup_run != 8'hFF)
							dup_run = dup_run + 8'd1;
					end else begin
						freed = (adv < 32'(ring_count)) ? 17'(adv) : ring_count;
						if (32'(ring_head) + 32'(freed) >= ring_size)
							n_wraps++;
						ring_head = 16'((32'(ring_head) + 32'(freed)) % ring_size);
						ring_count = ring_count - freed;
						snd_una = w.ack_number;
						mss2 = 64'(reg_mss) * 64'(reg_mss);
						if (cwnd < reg_ssthresh) begin
							inc = 64'(reg_mss);
						end else if (cwnd == 0) begin
							inc = mss2;
						end else begin
							inc = mss2 / 64'(cwnd);
							n_avoid++;
						end
						if (inc == 0)
							inc = 64'd1;
						total = 64'(cwnd) + inc;
						cwnd = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
						dup_run = '0;
						n_new_acks++;
					end
					peer_win = w.window_size;
					rtt_gap = w.ack_number - rtt_mark;
					if (rtt_armed && !rtt_gap[31]) begin
						rtt_armed = 1'b0;
						rdone = 1'b1;
						n_rtt_done++;
					end
					if (adv != 0) begin
						rto = (snd_una != snd_nxt) ? RTO_REARM : RTO_CANCEL;
						if (rto == RTO_REARM)
							n_rearms++;
					end
				end
			end
			OP_DATA_QUEUED: begin
				fill = 32'(ring_count) + 32'(w.byte_count);
				ring_count = (fill > ring_size) ? 17'(ring_size) : 17'(fill);
			end
			OP_SEG_SENT: begin
				snd_nxt = snd_nxt + 32'(w.byte_count);
				if (w.start_rtt && !rtt_armed) begin
					rtt_armed = 1'b1;
					rtt_mark = snd_nxt;
				end
			end
			default: begin
			end
		endcase
		if (int'(dup_run) > peak_dups)
			peak_dups = int'(dup_run);
		return state_word(snd_una, cwnd, ring_head, ring_count, freed, dup_run, rdone, rto);
	endfunction

	function automatic in_word_t random_event();
		in_word_t    w;
		int          pick;
		logic [31:0] outstanding;
		w.op = 2'($urandom_range(0, 2));
		w.established = 1'($urandom);
		w.ack_flag = 1'($urandom);
		w.ack_number = $urandom;
		w.window_size = 16'($urandom);
		w.segment_data_len = 16'($urandom);
		w.byte_count = 17'($urandom_range(0, 65536));
		w.start_rtt = 1'($urandom);
		outstanding = snd_nxt - snd_una;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			w.op = OP_SEG_ARRIVED;
			w.established = 1'b1;
			w.ack_flag = 1'b1;
			case ($urandom_range(0, 3))
				0, 1: w.ack_number = snd_una + ((outstanding != 0 && !outstanding[31])
					? $urandom_range(1, outstanding) : $urandom_range(1, 3000));
				2: w.ack_number = snd_una + $urandom_range(1, 70000);
				default: w.ack_number = snd_una + $urandom_range(1, 32'h7FFF_FFFF);
			endcase
			if ($urandom_range(0, 1))
				w.segment_data_len = '0;
		end else if (pick < 45) begin
			w.op = OP_SEG_ARRIVED;
			w.established = 1'b1;
			w.ack_flag = 1'b1;
			w.ack_number = snd_una;
			if ($urandom_range(0, 5) != 0)
				w.segment_data_len = '0;
			if ($urandom_range(0, 5) != 0)
				w.window_size = peer_win;
		end else if (pick < 60) begin
			w.op = OP_DATA_QUEUED;
			case ($urandom_range(0, 7))
				0: w.byte_count = 17'd65536;
				1: w.byte_count = 17'($urandom_range(0, 65536));
				default: w.byte_count = 17'($urandom_range(0, 3000));
			endcase
		end else if (pick < 78) begin
			w.op = OP_SEG_SENT;
			if ($urandom_range(0, 7) != 0)
				w.byte_count = 17'($urandom_range(0, 3000));
			w.start_rtt = ($urandom_range(0, 2) == 0);
		end else if (pick < 88) begin
			w.op = OP_SEG_ARRIVED;
			w.established = 1'b1;
			w.ack_flag = 1'b1;
			w.ack_number = snd_una + 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
		end else if (pick < 97) begin
			w.op = 2'($urandom);
		end else begin
			w.op = OP_RESERVED;
		end
		return w;
	endfunction

	task automatic offer_event(in_word_t w, logic typed, out_word_t want);
		out_word_t pred;
		int        gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
		end
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		pred = ack_update(w);
		pending_states.push_back(typed ? want : pred);
		n_words++;
	endtask

	task automatic wait_results_drained();
		while (pending_states.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_config(logic [15:0] mss, logic [31:0] ssth, logic [16:0] sndbuf);
		logic [1:0]  idx;
		logic [31:0] val;
		cfg_valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			idx = 2'(i);
			case (idx)
				CFG_MSS: val = 32'(mss);
				CFG_SSTHRESH: val = ssth;
				default: val = 32'(sndbuf);
			endcase
			cfg_index <= idx;
			cfg_data <= val;
			do @(posedge clk); while (!cfg_ready);
			case (idx)
				CFG_MSS: reg_mss = val[15:0];
				CFG_SSTHRESH: reg_ssthresh = val;
				default: reg_sndbuf = val[16:0];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= 40)
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_states.size() == 0) begin
				n_errors++;
				if (n_errors <= 40)
					$display("%0t ns: word expected none, got %h", $time, out_data);
			end else begin
				want = pending_states.pop_front();
				compare_field("unacked_seq", want.unacked_seq, out_data.unacked_seq);
				compare_field("congestion_window", want.congestion_window,
					out_data.congestion_window);
				compare_field("buffer_start", 32'(want.buffer_start), 32'(out_data.buffer_start));
				compare_field("buffer_len", 32'(want.buffer_len), 32'(out_data.buffer_len));
				compare_field("bytes_freed", 32'(want.bytes_freed), 32'(out_data.bytes_freed));
				compare_field("dup_ack_count", 32'(want.dup_ack_count),
					32'(out_data.dup_ack_count));
				compare_field("rtt_done", 32'(want.rtt_done), 32'(out_data.rtt_done));
				compare_field("rto_action", 32'(want.rto_action), 32'(out_data.rto_action));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t ns: no word moved for %0d cycles", $time, quiet);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// The receiver mixes always ready, coin flips, one cycle in four and hold_req stalls.
	initial begin
		int mode;
		int span;
		int tick;
		out_ready = 1'b0;
		tick = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(5, 60);
				repeat (span) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom);
						default: out_ready <= (tick % 4 == 0);
					endcase
					tick++;
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		stim_row_t dir_rows [N_DIRECTED];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		burst_left = 0;
		quiet = 0;
		reg_mss = MSS_RESET;
		reg_ssthresh = SSTHRESH_RESET;
		reg_sndbuf = SNDBUF_RESET;
		snd_una = '0;
		snd_nxt = '0;
		ring_head = '0;
		ring_count = '0;
		cwnd = CWND_RESET;
		dup_run = '0;
		peer_win = '0;
		rtt_armed = 1'b0;
		rtt_mark = '0;

		dir_rows = '{
			'{event_word(OP_RESERVED, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 17'd65536,
				1'b1), 1'b1, state_word(0, 536, 0, 0, 0, 0, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_ARRIVED, 1'b0, 1'b1, 32'd5, 0, 0, 0, 1'b0), 1'b1,
				state_word(0, 536, 0, 0, 0, 0, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b0, 32'd5, 0, 0, 0, 1'b0), 1'b1,
				state_word(0, 536, 0, 0, 0, 0, 1'b0, RTO_NONE)},
			'{event_word(OP_DATA_QUEUED, 1'b0, 1'b0, 0, 0, 0, 17'd65536, 1'b0), 1'b1,
				state_word(0, 536, 0, 17'd65536, 0, 0, 1'b0, RTO_NONE)},
			'{event_word(OP_DATA_QUEUED, 1'b0, 1'b0, 0, 0, 0, 17'd1, 1'b0), 1'b1,
				state_word(0, 536, 0, 17'd65536, 0, 0, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_SENT, 1'b0, 1'b0, 0, 0, 0, 17'd65536, 1'b1), 1'b1,
				state_word(0, 536, 0, 17'd65536, 0, 0, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_SENT, 1'b0, 1'b0, 0, 0, 0, 17'd0, 1'b1), 1'b1,
				state_word(0, 536, 0, 17'd65536, 0, 0, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd0, 16'd0, 0, 0, 1'b0), 1'b1,
				state_word(0, 536, 0, 17'd65536, 0, 1, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd0, 16'd100, 0, 0, 1'b0), 1'b1,
				state_word(0, 536, 0, 17'd65536, 0, 1, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd0, 16'd100, 0, 0, 1'b0), 1'b1,
				state_word(0, 536, 0, 17'd65536, 0, 2, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'h8000_0000, 16'd7, 0, 0, 1'b0), 1'b1,
				state_word(0, 536, 0, 17'd65536, 0, 2, 1'b0, RTO_NONE)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd1000, 16'hFFFF, 16'hFFFF, 0, 1'b0),
				1'b1, state_word(1000, 1072, 1000, 17'd64536, 17'd1000, 0, 1'b0, RTO_REARM)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd65536, 16'd100, 0, 0, 1'b0), 1'b1,
				state_word(65536, 1608, 0, 0, 17'd64536, 0, 1'b1, RTO_CANCEL)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd70000, 16'd100, 0, 0, 1'b0), 1'b1,
				state_word(70000, 2144, 0, 0, 0, 0, 1'b0, RTO_REARM)},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd70000, 16'd100, 0, 0, 1'b0), 1'b1,
				state_word(70000, 2144, 0, 0, 0, 1, 1'b0, RTO_NONE)},
			'{event_word(OP_DATA_QUEUED, 1'b0, 1'b0, 0, 0, 0, 17'd12345, 1'b0), 1'b0, '0},
			'{event_word(OP_SEG_SENT, 1'b0, 1'b0, 0, 0, 0, 17'd30000, 1'b1), 1'b0, '0},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd80000, 0, 0, 0, 1'b0), 1'b0, '0},
			'{event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, 32'd95536, 0, 0, 0, 1'b0), 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph != 0) begin
				wait_results_drained();
				case (ph)
					1: set_config(16'd65535, 32'd1, 17'd1);
					2: set_config(16'd1, 32'hFFFF_FFFF, 17'd65536);
					3: set_config(16'd1460, 32'd20000, 17'd1000);
					4: set_config(16'($urandom_range(1, 65535)), $urandom_range(1, 200000),
						17'($urandom_range(1, 65536)));
					default: set_config(16'd65535, 32'hFFFF_FFFF, 17'd257);
				endcase
			end
			if (ph == 0) begin
				for (int i = 0; i < N_DIRECTED; i++)
					offer_event(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
			end
			if (ph == 3) begin
				for (int i = 0; i < DUP_RUN; i++)
					offer_event(event_word(OP_SEG_ARRIVED, 1'b1, 1'b1, snd_una, peer_win, 16'd0,
						17'($urandom_range(0, 65536)), 1'($urandom)), 1'b0, '0);
			end
			if (ph == 4)
				hold_req = 1'b1;
			for (int k = 0; k < RANDOM_PER_PHASE; k++)
				offer_event(random_event(), 1'b0, '0);
			in_valid <= 1'b0;
			burst_left = 0;
		end

		wait_results_drained();
		repeat (100) @(posedge clk);
		$display("Ran %0d event words over six register settings: %0d new acks, %0d of them in",
			n_words, n_new_acks, n_avoid);
		$display("congestion avoidance, %0d buffer wraps, %0d round trips, %0d rearms, peak dups %0d.",
			n_wraps, n_rtt_done, n_rearms, peak_dups);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
